// ===== rtl/armt_pkg.sv =====
package armt_pkg;

   localparam int DEF_MAX_RANGES = 16;
   localparam int WORD_W         = 64;
   localparam int COUNT_OUT_W    = 5;
   localparam int REQ_TDATA_W    = 5 * WORD_W;
   localparam int REQ_TUSER_W    = 1;
   localparam int RSP_TDATA_W    = 8;
   localparam int RANGE_W        = 2 * WORD_W;

   localparam logic OP_RECORD   = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic load;
      logic sum;
      logic clip;
      logic start;
      logic rd;
      logic eval;
      logic copy;
      logic tail;
      logic clear;
      logic commit;
      logic rsp_load;
   } armt_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic fail;
      logic empty;
      logic clip_empty;
      logic has_more;
      logic defer;
   } armt_sts_type;

endpackage

// ===== rtl/ack_range_merge_tracker_top.sv =====
// Channel | Dir | Beat content
// req     | in  | tdata: 5 x 64-bit range/window words; tuser: operation
// rsp     | out | tdata: status, window_acked, range_count (one beat per req beat)
//
// Record beat: SUM, CHECK, TEST, a merge pass reading each stored range (READ, EVAL)
// with a COPY step where one lies above the new range, then TAIL, JUDGE. Clear beat
// ends after SUM, failing or empty after CHECK, clipped to nothing after TEST.
// Reset empties the list at once (fill count only, no clearing pass).
// A finished result waits in the output register; a new req beat is taken
// while it waits, and the next result holds until rsp_tready frees the slot.
module ack_range_merge_tracker_top #(
   parameter int MAX_RANGES = armt_pkg::DEF_MAX_RANGES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // ack_offset, ack_length, window_base, sent_length, queued_length
   input  logic [armt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic [armt_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, window_acked, range_count, zero pad
   output logic [armt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import armt_pkg::*;

   armt_cmd_type cmd;
   armt_sts_type sts;

   armt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   armt_dp #(
      .MAX_RANGES (MAX_RANGES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/armt_ram.sv =====
module armt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/armt_dp.sv =====
module armt_dp #(
   parameter int MAX_RANGES = armt_pkg::DEF_MAX_RANGES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  armt_pkg::armt_cmd_type            cmd,
   output armt_pkg::armt_sts_type            sts,
   input  logic [armt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [armt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic [armt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import armt_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int DEPTH = 2 * MAX_RANGES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]    BANK_OFS = AW'(MAX_RANGES);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RANGES);

   logic              op_ff;
   logic [WORD_W-1:0] off_ff, len_ff, base_ff, sent_ff, queued_ff;
   logic [WORD_W-1:0] ack_end_ff, ack_end_in, sent_end_ff, sent_end_in;
   logic              off_lt_base_ff, off_lt_base_in;
   logic              fail_ff, fail_in, empty_ff, empty_in;
   logic              acked_ff, acked_in;
   logic [WORD_W-1:0] mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [CNT_W-1:0]  rd_ff, rd_in, wr_ff, wr_in, count_ff, count_in;
   logic              placed_ff, placed_in, absorbed_ff, absorbed_in;
   logic              bank_ff, bank_in;
   logic [WORD_W-1:0] first_lo_ff, first_lo_in, first_hi_ff, first_hi_in;
   logic [RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [WORD_W:0]   ack_sum, sent_sum;
   logic [RANGE_W-1:0] ram_rdata, ram_wdata;
   logic [WORD_W-1:0] r_begin, r_limit;
   logic              ram_we, below, after, full;
   logic [AW-1:0]     ram_waddr, ram_raddr;

   assign ack_sum  = {1'b0, off_ff} + {1'b0, len_ff};
   assign sent_sum = {1'b0, base_ff} + {1'b0, sent_ff};
   assign r_begin  = ram_rdata[WORD_W-1:0];
   assign r_limit  = ram_rdata[RANGE_W-1:WORD_W];
   assign below    = r_limit < mlo_ff;
   assign after    = r_begin > mhi_ff;
   assign full     = (count_ff == CNT_MAX) && !absorbed_ff;

   assign ram_raddr = AW'(rd_ff[IDX_W-1:0]) + (bank_ff ? BANK_OFS : '0);
   assign ram_waddr = AW'(wr_ff[IDX_W-1:0]) + (bank_ff ? '0 : BANK_OFS);

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = ram_rdata;
      if (cmd.eval) begin
         if (placed_ff || below) begin
            ram_we = 1'b1;
         end else if (after && !full) begin
            ram_we    = 1'b1;
            ram_wdata = {mhi_ff, mlo_ff};
         end
      end else if (cmd.copy) begin
         ram_we = 1'b1;
      end else if (cmd.tail && !placed_ff && !full) begin
         ram_we    = 1'b1;
         ram_wdata = {mhi_ff, mlo_ff};
      end
   end

   always_comb begin
      ack_end_in     = ack_end_ff;
      sent_end_in    = sent_end_ff;
      off_lt_base_in = off_lt_base_ff;
      fail_in        = fail_ff;
      empty_in       = empty_ff;
      acked_in       = acked_ff;
      mlo_in         = mlo_ff;
      mhi_in         = mhi_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      count_in       = count_ff;
      placed_in      = placed_ff;
      absorbed_in    = absorbed_ff;
      bank_in        = bank_ff;
      first_lo_in    = first_lo_ff;
      first_hi_in    = first_hi_ff;
      rsp_in         = rsp_ff;
      if (cmd.load) begin
         fail_in  = STATUS_OK;
         acked_in = 1'b0;
      end
      if (cmd.sum) begin
         ack_end_in     = ack_sum[WORD_W-1:0];
         sent_end_in    = sent_sum[WORD_W-1:0];
         off_lt_base_in = off_ff < base_ff;
         fail_in        = ack_sum[WORD_W] | (queued_ff < sent_ff) | sent_sum[WORD_W];
         empty_in       = (len_ff == '0) || (sent_ff == '0);
      end
      if (cmd.clip) begin
         mlo_in = off_lt_base_ff ? base_ff : off_ff;
         mhi_in = (ack_end_ff > sent_end_ff) ? sent_end_ff : ack_end_ff;
      end
      if (cmd.start) begin
         rd_in       = '0;
         wr_in       = '0;
         placed_in   = 1'b0;
         absorbed_in = 1'b0;
      end
      if (cmd.eval) begin
         rd_in = rd_ff + 1'b1;
         if (!placed_ff && !below) begin
            if (after) begin
               placed_in = 1'b1;
            end else begin
               absorbed_in = 1'b1;
               if (r_begin < mlo_ff) begin
                  mlo_in = r_begin;
               end
               if (r_limit > mhi_ff) begin
                  mhi_in = r_limit;
               end
            end
         end
      end
      if (ram_we) begin
         wr_in = wr_ff + 1'b1;
         if (wr_ff == '0) begin
            first_lo_in = ram_wdata[WORD_W-1:0];
            first_hi_in = ram_wdata[RANGE_W-1:WORD_W];
         end
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.commit) begin
         count_in = wr_ff;
         bank_in  = ~bank_ff;
         acked_in = (first_lo_ff <= base_ff) && (first_hi_ff >= sent_end_ff);
      end
      if (cmd.rsp_load) begin
         rsp_in = {1'b0, COUNT_OUT_W'(count_ff), acked_ff, fail_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_tuser[0];
         off_ff    <= req_tdata[WORD_W-1:0];
         len_ff    <= req_tdata[2*WORD_W-1:WORD_W];
         base_ff   <= req_tdata[3*WORD_W-1:2*WORD_W];
         sent_ff   <= req_tdata[4*WORD_W-1:3*WORD_W];
         queued_ff <= req_tdata[5*WORD_W-1:4*WORD_W];
      end
      ack_end_ff     <= ack_end_in;
      sent_end_ff    <= sent_end_in;
      off_lt_base_ff <= off_lt_base_in;
      fail_ff        <= fail_in;
      empty_ff       <= empty_in;
      acked_ff       <= acked_in;
      mlo_ff         <= mlo_in;
      mhi_ff         <= mhi_in;
      rd_ff          <= rd_in;
      wr_ff          <= wr_in;
      placed_ff      <= placed_in;
      absorbed_ff    <= absorbed_in;
      first_lo_ff    <= first_lo_in;
      first_hi_ff    <= first_hi_in;
      rsp_ff         <= rsp_in;
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

   armt_ram #(
      .WIDTH (RANGE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign sts.is_clear   = (op_ff == OP_CLEAR);
   assign sts.fail       = fail_ff;
   assign sts.empty      = empty_ff;
   assign sts.clip_empty = !(mlo_ff < mhi_ff);
   assign sts.has_more   = rd_ff < count_ff;
   assign sts.defer      = !placed_ff && !below && after;
   assign rsp_tdata      = rsp_ff;

endmodule

// ===== rtl/armt_ctrl.sv =====
module armt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output armt_pkg::armt_cmd_type cmd,
   input  armt_pkg::armt_sts_type sts
);

   import armt_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_SUM   = 10'b00_0000_0010,
      S_CHECK = 10'b00_0000_0100,
      S_TEST  = 10'b00_0000_1000,
      S_READ  = 10'b00_0001_0000,
      S_EVAL  = 10'b00_0010_0000,
      S_COPY  = 10'b00_0100_0000,
      S_TAIL  = 10'b00_1000_0000,
      S_JUDGE = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } armt_state_type;

   armt_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sts.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.sum  = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.fail || sts.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.clip = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            cmd.start = 1'b1;
            state_in  = sts.clip_empty ? S_DONE : S_READ;
         end
         S_READ: begin
            if (sts.has_more) begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.defer ? S_COPY : S_READ;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            state_in = S_READ;
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            state_in = S_JUDGE;
         end
         S_JUDGE: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== tb/range_tracker_checker.sv =====
module range_tracker_checker #(
   parameter int MAX_RANGES = armt_pkg::DEF_MAX_RANGES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // ack_offset, ack_length, window_base, sent_length, queued_length
   input  logic [armt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation
   input  logic [armt_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, window_acked, range_count, zero pad
   input  logic [armt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               outstanding,
   output int                               merged_beats,
   output int                               clear_beats,
   output int                               fail_beats,
   output int                               acked_beats,
   output int                               dropped_beats
);
   timeunit 1ns;
   timeprecision 1ps;
   import armt_pkg::*;

   typedef struct packed {
      logic                   status;
      logic                   acked;
      logic [COUNT_OUT_W-1:0] count;
   } tracker_rsp_type;

   logic [WORD_W-1:0] span_lo [MAX_RANGES];
   logic [WORD_W-1:0] span_hi [MAX_RANGES];
   int                held;
   tracker_rsp_type   awaited_rsp [$];

   task automatic predict_ack_range(input logic op, input logic [WORD_W-1:0] off, len, base,
                                    sent, queued, output tracker_rsp_type res);
      logic [WORD_W:0]   ack_end;
      logic [WORD_W:0]   win_end;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] mlo;
      logic [WORD_W-1:0] mhi;
      int                pos;
      int                i;
      begin
         res        = '0;
         res.status = STATUS_OK;
         ack_end    = {1'b0, off} + {1'b0, len};
         win_end    = {1'b0, base} + {1'b0, sent};
         if (op == OP_CLEAR) begin
            for (i = 0; i < MAX_RANGES; i++) begin
               span_lo[i] = '0;
               span_hi[i] = '0;
            end
            held = 0;
            clear_beats++;
         end else if (ack_end[WORD_W] || queued < sent || win_end[WORD_W]) begin
            res.status = STATUS_FAIL;
            fail_beats++;
         end else if (len != 0 && sent != 0) begin
            lo = (off < base) ? base : off;
            hi = (ack_end[WORD_W-1:0] > win_end[WORD_W-1:0]) ? win_end[WORD_W-1:0]
                                                               : ack_end[WORD_W-1:0];
            if (lo < hi) begin
               merged_beats++;
               pos = 0;
               mlo = lo;
               mhi = hi;
               while (pos < held) begin
                  if (span_hi[pos] < mlo) begin
                     pos++;
                  end else if (span_lo[pos] > mhi) begin
                     break;
                  end else begin
                     if (span_lo[pos] < mlo) mlo = span_lo[pos];
                     if (span_hi[pos] > mhi) mhi = span_hi[pos];
                     for (i = pos; i + 1 < held; i++) begin
                        span_lo[i] = span_lo[i+1];
                        span_hi[i] = span_hi[i+1];
                     end
                     held--;
                     span_lo[held] = '0;
                     span_hi[held] = '0;
                  end
               end
               if (held < MAX_RANGES) begin
                  for (i = held; i > pos; i--) begin
                     span_lo[i] = span_lo[i-1];
                     span_hi[i] = span_hi[i-1];
                  end
                  span_lo[pos] = mlo;
                  span_hi[pos] = mhi;
                  held++;
               end else begin
                  dropped_beats++;
               end
               if (held != 0 && span_lo[0] <= base && span_hi[0] >= win_end[WORD_W-1:0]) begin
                  res.acked = 1'b1;
                  acked_beats++;
               end
            end
         end
         res.count = held[COUNT_OUT_W-1:0];
      end
   endtask

   always @(posedge clock) begin
      tracker_rsp_type want;
      tracker_rsp_type got;
      if (reset) begin
         for (int i = 0; i < MAX_RANGES; i++) begin
            span_lo[i] = '0;
            span_hi[i] = '0;
         end
         held = 0;
         awaited_rsp.delete();
         error_count   = 0;
         merged_beats  = 0;
         clear_beats   = 0;
         fail_beats    = 0;
         acked_beats   = 0;
         dropped_beats = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[0];
            got.acked  = rsp_tdata[1];
            got.count  = rsp_tdata[2 +: COUNT_OUT_W];
            if (awaited_rsp.size() == 0) begin
               $error("rsp beat with nothing expected: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.acked !== want.acked) begin
                  $error("window_acked: expected %0d, actual %0d", want.acked, got.acked);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $error("range_count: expected %0d, actual %0d", want.count, got.count);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_ack_range(req_tuser[0], req_tdata[0 +: WORD_W], req_tdata[WORD_W +: WORD_W],
                              req_tdata[2*WORD_W +: WORD_W], req_tdata[3*WORD_W +: WORD_W],
                              req_tdata[4*WORD_W +: WORD_W], want);
            awaited_rsp.push_back(want);
         end
      end
      outstanding = awaited_rsp.size();
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import armt_pkg::*;

   localparam logic [WORD_W-1:0] WORD_MAX = '1;
   localparam logic [WORD_W-1:0] WORD_TOP = {1'b1, {(WORD_W-1){1'b0}}};

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   no_idle    = 1'b0;

   int req_taken = 0;
   int rsp_taken = 0;
   int error_count;
   int outstanding;
   int merged_beats;
   int clear_beats;
   int fail_beats;
   int acked_beats;
   int dropped_beats;

   ack_range_merge_tracker_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   range_tracker_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .merged_beats  (merged_beats),
      .clear_beats   (clear_beats),
      .fail_beats    (fail_beats),
      .acked_beats   (acked_beats),
      .dropped_beats (dropped_beats)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) req_taken <= req_taken + 1;
      if (!reset && rsp_tvalid && rsp_tready) rsp_taken <= rsp_taken + 1;
   end

   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_beat(input logic op, input logic [WORD_W-1:0] off, len, base, sent,
                            queued);
      int gap;
      int taken_before;
      begin
         gap = idle_cycles();
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid   <= 1'b1;
         req_tuser    <= op;
         req_tdata    <= {queued, sent, base, len, off};
         taken_before = req_taken;
         do @(negedge clock); while (req_taken == taken_before);
      end
   endtask

   task automatic run_random(input int n);
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] sent;
      logic [WORD_W-1:0] queued;
      logic [WORD_W-1:0] off;
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] s;
      int                len_cap;
      int                kind;
      begin
         base = '0;
         sent = 64;
         queued = 64;
         len_cap = 8;
         for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
               sent = WORD_W'($urandom_range(64, 4000));
               case ($urandom_range(0, 2))
                  0:       base = WORD_W'($urandom_range(0, 100000));
                  1:       base = rand_word();
                  default: base = WORD_MAX - sent - $urandom_range(0, 50);
               endcase
               if (base > WORD_MAX - sent) base = WORD_MAX - sent;
               queued  = sent + $urandom_range(0, 1000);
               len_cap = $urandom_range(0, 1) ? 8 : 80;
               no_idle = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
               off = base + $urandom_range(0, 32'(sent) + 40) - 20;
               len = WORD_W'($urandom_range(1, len_cap));
               if ($urandom_range(0, 19) == 0) begin
                  off = base + $urandom_range(0, 20);
                  len = sent;
               end
               send_beat(OP_RECORD, off, len, base, sent, queued);
            end else if (kind < 75) begin
               send_beat(OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word());
            end else if (kind < 85) begin
               case ($urandom_range(0, 2))
                  0: begin
                     off = rand_word() | WORD_TOP;
                     len = ~off + 1 + $urandom_range(0, 1000);
                     send_beat(OP_RECORD, off, len, base, sent, queued);
                  end
                  1: begin
                     send_beat(OP_RECORD, base + 10, 20, base, sent,
                               sent - 1 - $urandom_range(0, 63));
                  end
                  default: begin
                     b = rand_word() | WORD_TOP;
                     s = ~b + 1 + $urandom_range(0, 1000);
                     send_beat(OP_RECORD, b, 5, b, s, s + $urandom_range(0, 10));
                  end
               endcase
            end else if (kind < 91) begin
               if ($urandom_range(0, 1))
                  send_beat(OP_RECORD, base + 3, 0, base, sent, queued);
               else
                  send_beat(OP_RECORD, base + 3, 10, base, 0, queued);
            end else begin
               send_beat(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word());
            end
         end
      end
   endtask

   initial begin
      int taken_before;
      int gap;
      wait (!reset);
      forever begin
         gap = idle_cycles();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready   <= 1'b1;
         taken_before = rsp_taken;
         do @(negedge clock); while (rsp_taken == taken_before);
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(OP_RECORD, 100, 10, 0, 1000, 1000);
      send_beat(OP_RECORD, 110, 5, 0, 1000, 1000);     // touches end
      send_beat(OP_RECORD, 200, 10, 0, 1000, 1000);    // disjoint
      send_beat(OP_RECORD, 115, 85, 0, 1000, 1000);    // bridges both
      send_beat(OP_RECORD, 2000, 10, 0, 1000, 1000);   // clipped to nothing
      send_beat(OP_RECORD, 5, 0, 0, 1000, 1000);       // empty ack
      send_beat(OP_RECORD, 5, 10, 0, 0, 0);            // empty window
      send_beat(OP_RECORD, WORD_MAX, 1, 0, 1000, 1000);
      send_beat(OP_RECORD, 5, 10, 0, 1000, 999);
      send_beat(OP_RECORD, 5, 10, WORD_MAX, 2, 2);
      send_beat(OP_RECORD, 0, 1000, 0, 1000, 1000);    // whole window
      send_beat(OP_RECORD, 0, WORD_MAX, WORD_MAX - 10, 10, WORD_MAX);
      send_beat(OP_CLEAR, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      for (int k = 0; k < DEF_MAX_RANGES; k++)
         send_beat(OP_RECORD, WORD_W'(10 * k + 1), 5, 0, 1000, 1000);
      send_beat(OP_RECORD, 500, 5, 0, 1000, 1000);     // list full, dropped
      send_beat(OP_RECORD, 7, 4, 0, 1000, 1000);       // absorbs one, stays full
      send_beat(OP_RECORD, 6, 1, 0, 1000, 1000);       // joins two

      run_random(500);

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (60) @(negedge clock);

      $display("Run: %0d merging records, %0d clears, %0d failing beats, %0d full-list drops.",
               merged_beats, clear_beats, fail_beats, dropped_beats);
      $display("     %0d beats saw the whole sent window acknowledged.", acked_beats);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
